// ===== sv/gas_pkg.sv =====
// Shared types, constants and helpers for the global alignment score unit.
package gas_pkg;

  // Field and register widths
  localparam int SYM_W   = 8;
  localparam int CFG_W   = 5;
  localparam int SCORE_W = 18;
  localparam int WIDE_W  = SCORE_W + 2;
  localparam int CIDX_W  = 2;

  // Default query capacity
  localparam int MAX_QUERY_LEN_DEF = 1024;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CIDX_W-1:0] REG_GAP      = 2'd2;

  // Configuration reset values
  localparam logic signed [CFG_W-1:0] MATCH_RST    = 5'sd1;
  localparam logic signed [CFG_W-1:0] MISMATCH_RST = -5'sd1;
  localparam logic signed [CFG_W-1:0] GAP_RST      = -5'sd2;

  // Saturation limits of a score cell
  localparam logic signed [WIDE_W-1:0] SCORE_HI = WIDE_W'(131071);
  localparam logic signed [WIDE_W-1:0] SCORE_LO = -WIDE_W'(131072);

  // One wavefront element handed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic                      first;
    logic                      last;
    logic [SYM_W-1:0]          sym;
    logic signed [SCORE_W-1:0] left_new;  // this row, column to the left
    logic signed [SCORE_W-1:0] left_old;  // previous row, column to the left
    logic signed [SCORE_W-1:0] row0;      // first row, column to the left
  } gas_token_t;

  // Saturate a widened sum to the score range
  function automatic logic signed [SCORE_W-1:0] clamp_score(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [SCORE_W-1:0] r;
    if (v > SCORE_HI) begin
      r = SCORE_HI[SCORE_W-1:0];
    end else if (v < SCORE_LO) begin
      r = SCORE_LO[SCORE_W-1:0];
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/global_alignment_score_unit.sv =====
// Top level: global alignment score over a systolic row of query cells.
//
//  channel   signals                          direction  transaction
//  input     in_valid/in_ready, mode,symbol,last  in    one query or stream symbol
//  output    out_valid/out_ready, score           out   score of a finished stream
//  config    cfg_we, cfg_index, cfg_data          in    one register write
//
// A stream symbol enters every cycle unless a waiting result freezes the chain;
// its score row sweeps one cell per cycle from the entry register to the output.
// A query symbol is taken only once no stream symbol is left in the chain.
// Reset is synchronous; query and score cells need no clearing pass.
// A result waiting at the output freezes the whole chain and the input.
module global_alignment_score_unit #(
  parameter int MAX_QUERY_LEN = gas_pkg::MAX_QUERY_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [gas_pkg::SYM_W-1:0]          symbol,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gas_pkg::SCORE_W-1:0] score,
  input  logic                               cfg_we,
  input  logic [gas_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [gas_pkg::CFG_W-1:0]          cfg_data
);
  import gas_pkg::*;

  localparam int LEN_W = $clog2(MAX_QUERY_LEN + 1);
  localparam int CNT_W = $clog2(MAX_QUERY_LEN + 3);

  logic signed [CFG_W-1:0]   match_score;
  logic signed [CFG_W-1:0]   mismatch_score;
  logic signed [CFG_W-1:0]   gap_score;
  logic [LEN_W-1:0]          query_length;
  logic                      load_done;
  logic                      streaming;
  logic signed [SCORE_W-1:0] col0;
  logic [CNT_W-1:0]          inflight;

  logic                      advance;
  logic                      accept;
  logic                      enter;
  logic                      leave;
  logic                      load_we;
  logic                      clear;
  logic [LEN_W-1:0]          load_idx;
  logic signed [SCORE_W-1:0] diag0;
  logic signed [SCORE_W-1:0] col0_next;
  gas_token_t                src_next;
  gas_token_t                tok [MAX_QUERY_LEN+1];

  // Handshake and load control
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && (mode || (inflight == '0));
  assign accept   = in_valid && in_ready;
  assign enter    = accept && mode;
  assign leave    = advance && tok[MAX_QUERY_LEN].valid;
  assign clear    = accept && !mode && load_done;
  assign load_idx = load_done ? '0 : query_length;
  assign load_we  = accept && !mode && (load_idx < LEN_W'(MAX_QUERY_LEN));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_score    <= MATCH_RST;
      mismatch_score <= MISMATCH_RST;
      gap_score      <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH:    match_score    <= cfg_data;
        REG_MISMATCH: mismatch_score <= cfg_data;
        REG_GAP:      gap_score      <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Query length, load and stream tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      load_done    <= 1'b0;
      streaming    <= 1'b0;
    end else if (accept) begin
      if (!mode) begin
        query_length <= load_we ? load_idx + LEN_W'(1) : load_idx;
        load_done    <= last;
        streaming    <= 1'b0;
      end else begin
        load_done    <= 1'b1;
        streaming    <= !last;
      end
    end
  end

  // Column zero and the token that enters the chain
  always_comb begin
    diag0     = streaming ? col0 : '0;
    col0_next = clamp_score(WIDE_W'(diag0) + WIDE_W'(gap_score));
    src_next          = '0;
    src_next.valid    = enter;
    src_next.first    = !streaming;
    src_next.last     = last;
    src_next.sym      = symbol;
    src_next.left_new = col0_next;
    src_next.left_old = diag0;
    src_next.row0     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else if (advance) begin
      tok[0] <= src_next;
    end
    if (enter) begin
      col0 <= col0_next;
    end
  end

  // Count stream tokens still in the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (enter && !leave) begin
      inflight <= inflight + CNT_W'(1);
    end else if (leave && !enter) begin
      inflight <= inflight - CNT_W'(1);
    end
  end

  // Row of cells, one per query position
  for (genvar k = 0; k < MAX_QUERY_LEN; k++) begin : g_cell
    gas_cell #(
      .IDX   (k),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .advance        (advance),
      .clear          (clear),
      .load_we        (load_we),
      .load_idx       (load_idx),
      .load_sym       (symbol),
      .match_score    (match_score),
      .mismatch_score (mismatch_score),
      .gap_score      (gap_score),
      .tok_in         (tok[k]),
      .tok_out        (tok[k+1])
    );
  end

  // Output register: capture the final cell of a finished stream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tok[MAX_QUERY_LEN].valid && tok[MAX_QUERY_LEN].last;
    end
    if (advance) begin
      score <= tok[MAX_QUERY_LEN].left_new;
    end
  end

endmodule

// ===== sv/gas_cell.sv =====
// One systolic cell: holds one query symbol and its column of the score row.
module gas_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 11
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               clear,
  input  logic                               load_we,
  input  logic [LEN_W-1:0]                   load_idx,
  input  logic [gas_pkg::SYM_W-1:0]          load_sym,
  input  logic signed [gas_pkg::CFG_W-1:0]   match_score,
  input  logic signed [gas_pkg::CFG_W-1:0]   mismatch_score,
  input  logic signed [gas_pkg::CFG_W-1:0]   gap_score,
  input  gas_pkg::gas_token_t                tok_in,
  output gas_pkg::gas_token_t                tok_out
);
  import gas_pkg::*;

  logic [SYM_W-1:0]          qsym;
  logic                      active;
  logic signed [SCORE_W-1:0] cell_score;

  logic                      hit;
  logic signed [SCORE_W-1:0] row0_self;
  logic signed [SCORE_W-1:0] up;
  logic signed [CFG_W-1:0]   pair;
  logic signed [WIDE_W-1:0]  from_diag;
  logic signed [WIDE_W-1:0]  from_up;
  logic signed [WIDE_W-1:0]  from_left;
  logic signed [WIDE_W-1:0]  best;
  logic signed [SCORE_W-1:0] new_score;
  gas_token_t                tok_next;

  assign hit = load_we && (load_idx == LEN_W'(IDX));

  // Hold the query symbol and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (hit) begin
      active <= 1'b1;
    end else if (clear) begin
      active <= 1'b0;
    end
    if (hit) begin
      qsym <= load_sym;
    end
  end

  // Compute this column's cell for the passing row
  always_comb begin
    row0_self = clamp_score(WIDE_W'(tok_in.row0) + WIDE_W'(gap_score));
    up        = tok_in.first ? row0_self : cell_score;
    pair      = (qsym == tok_in.sym) ? match_score : mismatch_score;
    from_diag = WIDE_W'(tok_in.left_old) + WIDE_W'(pair);
    from_up   = WIDE_W'(up) + WIDE_W'(gap_score);
    from_left = WIDE_W'(tok_in.left_new) + WIDE_W'(gap_score);
    best      = (from_diag > from_up) ? from_diag : from_up;
    best      = (best > from_left) ? best : from_left;
    new_score = clamp_score(best);

    tok_next = tok_in;
    if (active) begin
      tok_next.left_new = new_score;
      tok_next.left_old = up;
      tok_next.row0     = row0_self;
    end
  end

  // Advance the wavefront and store the new column value
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
    if (advance && tok_in.valid && active) begin
      cell_score <= new_score;
    end
  end

endmodule

// ===== verif/tb_global_alignment_score_unit.sv =====
// Self-checking testbench for the global alignment score unit.
`timescale 1ns / 1ps

module tb_global_alignment_score_unit;
  import gas_pkg::*;

  localparam int MAX_Q        = MAX_QUERY_LEN_DEF;
  localparam int ROW_POS_MAX  = 2047;
  localparam int SCORE_CEIL   = 131071;
  localparam int SCORE_FLOOR  = -131072;
  localparam int DRAIN_CYCLES = MAX_Q + 8;
  localparam int HOLD_CYCLES  = 3000;
  localparam int QUIET_LIMIT  = 20000;
  localparam int RST_CYCLES   = 12;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      mode      = 1'b0;
  logic [SYM_W-1:0]          symbol    = '0;
  logic                      last      = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SCORE_W-1:0] score;
  logic                      cfg_we    = 1'b0;
  logic [CIDX_W-1:0]         cfg_index = REG_MATCH;
  logic [CFG_W-1:0]          cfg_data  = '0;

  // Pacing knobs, percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_pending   = 1'b0;

  // Alignment predictor state
  logic [SYM_W-1:0]          query_mem [MAX_Q];
  int                        query_len;
  int                        dp_row [MAX_Q + 1];
  int                        row_pos;
  bit                        load_closed;
  int                        w_match;
  int                        w_mismatch;
  int                        w_gap;
  logic signed [SCORE_W-1:0] pending_scores [$];
  logic signed [SCORE_W-1:0] want;

  int symbols_taken  = 0;
  int scores_checked = 0;
  int fault_count    = 0;
  int quiet_cycles   = 0;

  global_alignment_score_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .symbol    (symbol),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .score     (score),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Saturate a cell to the 18-bit score range
  function automatic int clip_score(input int v);
    if (v > SCORE_CEIL) return SCORE_CEIL;
    if (v < SCORE_FLOOR) return SCORE_FLOOR;
    return v;
  endfunction

  // Fold one accepted symbol into the query or the running DP row
  function automatic void absorb_symbol(input logic m, input logic [SYM_W-1:0] s,
                                        input logic l);
    int diag;
    int up;
    int pair;
    int best;
    int run;
    if (!m) begin
      if (load_closed) begin
        query_len   = 0;
        load_closed = 1'b0;
      end
      if (query_len < MAX_Q) begin
        query_mem[query_len] = s;
        query_len++;
      end
      if (l) load_closed = 1'b1;
      row_pos = 0;
      return;
    end
    load_closed = 1'b1;
    // Seed the first row at the start of a stream
    if (row_pos == 0) begin
      run       = 0;
      dp_row[0] = 0;
      for (int j = 1; j <= query_len; j++) begin
        run       = clip_score(run + w_gap);
        dp_row[j] = run;
      end
    end
    if (row_pos < ROW_POS_MAX) row_pos++;
    diag      = dp_row[0];
    dp_row[0] = clip_score(dp_row[0] + w_gap);
    for (int j = 1; j <= query_len; j++) begin
      up   = dp_row[j];
      pair = (query_mem[j-1] == s) ? w_match : w_mismatch;
      best = diag + pair;
      if (up + w_gap > best) best = up + w_gap;
      if (dp_row[j-1] + w_gap > best) best = dp_row[j-1] + w_gap;
      diag      = up;
      dp_row[j] = clip_score(best);
    end
    if (l) begin
      pending_scores.push_back(SCORE_W'(dp_row[query_len]));
      row_pos = 0;
    end
  endfunction

  // Track register writes and input transactions, check each output transaction
  always @(posedge clk) begin
    if (rst) begin
      w_match     = MATCH_RST;
      w_mismatch  = MISMATCH_RST;
      w_gap       = GAP_RST;
      query_len   = 0;
      row_pos     = 0;
      load_closed = 1'b0;
      pending_scores.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH:    w_match    = $signed(cfg_data);
          REG_MISMATCH: w_mismatch = $signed(cfg_data);
          REG_GAP:      w_gap      = $signed(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        symbols_taken++;
        absorb_symbol(mode, symbol, last);
      end
      if (out_valid && out_ready) begin
        if (pending_scores.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected score %0d with no alignment pending", score);
        end else begin
          want = pending_scores.pop_front();
          scores_checked++;
          if (score !== want) begin
            fault_count++;
            if (fault_count <= 10)
              $display("score mismatch: expected %0d, got %0d", want, score);
          end
        end
      end
    end
  end

  // Drive out_ready: random stalls, or a long hold-off when requested
  always begin
    @(posedge clk);
    if (hold_pending) begin
      hold_pending = 1'b0;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // End the run if no transaction moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one symbol and hold it until the transaction completes
  task automatic send_symbol(input logic m, input logic [SYM_W-1:0] s, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    symbol   <= s;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send a run of printable symbols, marking the final one if asked
  task automatic send_text(input logic m, input string txt, input bit close);
    for (int k = 0; k < txt.len(); k++)
      send_symbol(m, txt[k], close && (k == txt.len() - 1));
  endtask

  // Drop valid, wait for every score, then let the chain empty
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three score registers, one per cycle
  task automatic program_scores(input int m, input int mm, input int g);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MATCH;
    cfg_data  <= CFG_W'(m);
    @(posedge clk);
    cfg_index <= REG_MISMATCH;
    cfg_data  <= CFG_W'(mm);
    @(posedge clk);
    cfg_index <= REG_GAP;
    cfg_data  <= CFG_W'(g);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a four-letter alphabet so matches are common
  function automatic logic [SYM_W-1:0] pick_symbol();
    logic [SYM_W-1:0] alpha [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
    if ($urandom_range(0, 99) < 80) return alpha[$urandom_range(0, 3)];
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // Reset scoring, empty query, byte extremes
  task automatic test_default_scoring();
    send_symbol(1'b1, 8'h00, 1'b0);
    send_symbol(1'b1, 8'hFF, 1'b1);
    send_symbol(1'b0, 8'h00, 1'b0);
    send_symbol(1'b0, 8'hFF, 1'b0);
    send_symbol(1'b0, 8'h5A, 1'b0);
    send_symbol(1'b0, 8'hA5, 1'b1);
    send_symbol(1'b1, 8'hFF, 1'b0);
    send_symbol(1'b1, 8'h00, 1'b0);
    send_symbol(1'b1, 8'hA5, 1'b1);
  endtask

  // Query restart, abandoned stream, load closed by a stream symbol
  task automatic test_sequence_control();
    send_text(1'b0, "AC", 1'b0);
    send_text(1'b0, "G", 1'b1);
    send_text(1'b0, "TA", 1'b1);
    send_text(1'b1, "TA", 1'b0);
    send_text(1'b0, "C", 1'b1);
    send_text(1'b1, "C", 1'b1);
    send_text(1'b1, "G", 1'b1);
    send_text(1'b0, "G", 1'b0);
    send_text(1'b1, "G", 1'b1);
  endtask

  // Extreme register values on a longer query and stream
  task automatic test_score_extremes();
    send_text(1'b0, "ACGTTGCA", 1'b1);
    settle_idle();
    program_scores(15, -16, 15);
    for (int k = 0; k < 24; k++) send_symbol(1'b1, (k % 2) ? 8'h43 : 8'h41, k == 23);
    settle_idle();
    program_scores(-16, -16, -16);
    for (int k = 0; k < 24; k++) send_symbol(1'b1, 8'h54, k == 23);
    settle_idle();
    program_scores(MATCH_RST, MISMATCH_RST, GAP_RST);
  endtask

  // Hold the output off while streams keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_text(1'b0, "GATTA", 1'b1);
    hold_pending = 1'b1;
    send_symbol(1'b1, pick_symbol(), 1'b0);
    send_symbol(1'b1, pick_symbol(), 1'b0);
    send_symbol(1'b1, pick_symbol(), 1'b1);
    // Let the first score reach the output so the frozen chain blocks the input
    in_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int k = 0; k < 15; k++) begin
      send_symbol(1'b1, pick_symbol(), 1'b0);
      send_symbol(1'b1, pick_symbol(), 1'b0);
      send_symbol(1'b1, pick_symbol(), 1'b1);
    end
  endtask

  // Random queries and streams, with some abandoned streams and open loads
  task automatic run_random_phase(input int unsigned idle_in, input int unsigned stall_out,
                                  input int m, input int mm, input int g,
                                  input int quota);
    int  sent;
    int  finished;
    int  len;
    bit  need_load;
    bit  open_end;
    bit  broken;
    sent      = 0;
    finished  = 0;
    need_load = 1'b0;
    settle_idle();
    program_scores(m, mm, g);
    send_idle_pct  = idle_in;
    recv_stall_pct = stall_out;
    while (sent < quota || finished < 3) begin
      if (need_load || $urandom_range(0, 99) < 70) begin
        len      = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        open_end = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++)
          send_symbol(1'b0, pick_symbol(), (k == len - 1) && !open_end);
        sent += len;
        need_load = 1'b0;
      end
      broken = ($urandom_range(0, 99) < 15);
      if (broken) len = $urandom_range(1, 5);
      else len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      for (int k = 0; k < len; k++)
        send_symbol(1'b1, pick_symbol(), (k == len - 1) && !broken);
      sent += len;
      if (broken) need_load = 1'b1;
      else finished++;
    end
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_default_scoring();
    test_sequence_control();
    test_score_extremes();
    test_output_backpressure();
    run_random_phase(0, 0, 15, -16, -16, 75);
    run_random_phase(59, 0, -16, 15, 15, 75);
    run_random_phase(0, 59, $urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16,
                     $urandom_range(0, 31) - 16, 75);
    run_random_phase(33, 33, 2, -3, -1, 75);
    settle_idle();
    $display("Run covered %0d symbols and %0d checked scores: empty queries, query restarts,",
             symbols_taken, scores_checked);
    $display("abandoned streams, extreme scoring values, output hold-off and four pacing mixes.");
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gas_pkg.sv
sv/gas_cell.sv
sv/global_alignment_score_unit.sv
verif/tb_global_alignment_score_unit.sv
